/* hw/rtl/hcsf_pkg.sv */
package hcsf_pkg;

  localparam int unsigned FreqW  = 22;
  localparam int unsigned BwW    = 12;
  localparam int unsigned HashW  = 32;
  localparam int unsigned ProdW  = 23;
  localparam int unsigned HzW    = 33;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StepW  = 5;

  localparam logic [HashW-1:0] HashSeed    = 32'd5381;
  localparam logic [FreqW-1:0] StartReset  = 22'd902000;
  localparam logic [FreqW-1:0] EndReset    = 22'd928000;
  localparam logic [BwW-1:0]   BwReset     = 12'd250;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAND_START = 2'd0,
    REG_BAND_END   = 2'd1,
    REG_CHANNEL_BW = 2'd2
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CNT  = 6'b000010,
    ST_LDM  = 6'b000100,
    ST_MOD  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic hash_en;
    logic load_cnt;
    logic step;
    logic load_mod;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/hcsf_ctrl.sv */
module hcsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_byte_i,
  output logic              in_stall_o,
  input  hcsf_pkg::sts_t    sts_i,
  output hcsf_pkg::cmd_t    cmd_o
);
  import hcsf_pkg::*;

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             cnt_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign cnt_last   = &cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          cmd_o.hash_en = 1'b1;
          if (last_byte_i) begin
            cmd_o.load_cnt = 1'b1;
            state_d        = ST_CNT;
          end
        end
      end
      ST_CNT: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_LDM;
        end
      end
      ST_LDM: begin
        cmd_o.load_mod = 1'b1;
        cnt_d          = '0;
        state_d        = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_last_starts_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> state_q == ST_CNT)
    else $error("last byte did not start the count division");

  a_mod_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LDM |=> state_q == ST_MOD && cnt_q == '0)
    else $error("modulo division did not start at step zero");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state is not one-hot");
`endif

endmodule

/* hw/rtl/hcsf_dp.sv */
module hcsf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hcsf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [hcsf_pkg::FreqW-1:0]          cfg_wdata_i,
  input  logic [7:0]                          name_byte_i,
  input  hcsf_pkg::cmd_t                      cmd_i,
  output hcsf_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [hcsf_pkg::HzW-1:0]            centre_freq_hz_o,
  output logic [hcsf_pkg::FreqW-1:0]          slot_index_o,
  output logic [hcsf_pkg::FreqW-1:0]          channel_count_o
);
  import hcsf_pkg::*;

  logic [FreqW-1:0] start_q, end_q;
  logic [BwW-1:0]   bw_q;
  logic [HashW-1:0] hash_q;
  logic [FreqW-1:0] rem_q, div_q, count_q;
  logic [HashW-1:0] quo_q;
  logic [ProdW-1:0] prod_q;
  logic             out_valid_q;
  logic [HzW-1:0]   freq_q;
  logic [FreqW-1:0] slot_q, chan_q;

  logic [BwW-1:0]   bw_eff;
  logic [FreqW-1:0] span;
  logic [FreqW:0]   shifted, diff;
  logic             ge;
  logic [FreqW-1:0] count_c;
  logic [BwW+ProdW-1:0] prod_full;
  logic [HzW-1:0]   freq_c;

  assign bw_eff  = (bw_q == '0) ? BwW'(1) : bw_q;
  assign span    = (end_q > start_q) ? (end_q - start_q) : '0;
  assign shifted = {rem_q, quo_q[HashW-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};
  assign count_c = (quo_q[FreqW-1:0] == '0) ? FreqW'(1) : quo_q[FreqW-1:0];
  assign prod_full = (BwW+ProdW)'(bw_eff) * (BwW+ProdW)'({rem_q, 1'b1});
  assign freq_c  = HzW'(start_q) * HzW'(1000) + HzW'(prod_q) * HzW'(500);

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
      end_q   <= EndReset;
      bw_q    <= BwReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BAND_START: start_q <= cfg_wdata_i;
        REG_BAND_END:   end_q   <= cfg_wdata_i;
        REG_CHANNEL_BW: bw_q    <= cfg_wdata_i[BwW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= HashSeed;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        hash_q <= HashSeed;
      end else if (cmd_i.hash_en) begin
        hash_q <= (hash_q << 5) + hash_q + HashW'(name_byte_i);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cnt) begin
      rem_q <= '0;
      quo_q <= HashW'(span);
      div_q <= FreqW'(bw_eff);
    end else if (cmd_i.load_mod) begin
      count_q <= count_c;
      rem_q   <= '0;
      quo_q   <= hash_q;
      div_q   <= count_c;
    end else if (cmd_i.step) begin
      rem_q <= ge ? diff[FreqW-1:0] : shifted[FreqW-1:0];
      quo_q <= {quo_q[HashW-2:0], ge};
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[ProdW-1:0];
    end
    if (cmd_i.emit) begin
      freq_q <= freq_c;
      slot_q <= rem_q;
      chan_q <= count_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign centre_freq_hz_o = freq_q;
  assign slot_index_o     = slot_q;
  assign channel_count_o  = chan_q;

`ifndef SYNTHESIS
  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || !out_stall_i)
    else $error("result overwritten while stalled");

  a_emit_reseeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && hash_q == HashSeed)
    else $error("hash not reseeded after result");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> rem_q < count_q)
    else $error("slot not below channel count");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_mod |=> count_q != '0)
    else $error("channel count is zero");
`endif

endmodule

/* hw/rtl/hashed_channel_slot_frequency_top.sv */
// a byte without the last mark is hashed as it is taken; the next request is taken the cycle after
// a last byte runs a count division, a load step and a hash modulo, each division over 32
// quotient bits (one shared restoring divider, one bit per cycle), then a multiply and an output step
// after a last byte the next request waits until the result is emitted, longer while the result stalls
// the finished result sits in an output register while new bytes are taken
// reset: band 902000..928000 khz, bandwidth 250 khz, hash 5381, no result pending
module hashed_channel_slot_frequency_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hcsf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hcsf_pkg::FreqW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   name_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hcsf_pkg::HzW-1:0]     centre_freq_hz_o,
  output logic [hcsf_pkg::FreqW-1:0]   slot_index_o,
  output logic [hcsf_pkg::FreqW-1:0]   channel_count_o
);
  import hcsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hcsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hcsf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .name_byte_i      (name_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .centre_freq_hz_o (centre_freq_hz_o),
    .slot_index_o     (slot_index_o),
    .channel_count_o  (channel_count_o)
  );

endmodule

/* sim/slot_freq_checker.sv */
module slot_freq_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hcsf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hcsf_pkg::FreqW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   name_byte_i,
  input  logic                         last_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [hcsf_pkg::HzW-1:0]     centre_freq_hz_i,
  input  logic [hcsf_pkg::FreqW-1:0]   slot_index_i,
  input  logic [hcsf_pkg::FreqW-1:0]   channel_count_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import hcsf_pkg::*;

  typedef struct packed {
    logic [HzW-1:0]   freq;
    logic [FreqW-1:0] slot;
    logic [FreqW-1:0] count;
  } slot_pick_t;

  logic [FreqW-1:0] start_khz;
  logic [FreqW-1:0] end_khz;
  logic [BwW-1:0]   bw_khz;
  logic [HashW-1:0] name_hash;
  slot_pick_t       pending_picks_q[$];
  int               fails;
  int               waiting;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  function automatic slot_pick_t pick_slot(input logic [HashW-1:0] hash);
    logic [31:0] bw;
    logic [31:0] count;
    logic [31:0] slot;
    logic [63:0] freq;
    slot_pick_t  pick;
    bw    = (bw_khz == '0) ? 32'd1 : 32'(bw_khz);
    count = 32'd0;
    if (end_khz > start_khz) begin
      count = 32'(end_khz - start_khz) / bw;
    end
    if (count == 32'd0) begin
      count = 32'd1;
    end
    slot = hash % count;
    freq = 64'(start_khz) * 64'd1000 + 64'(bw) * 64'd500 + 64'(slot) * 64'(bw) * 64'd1000;
    pick.freq  = freq[HzW-1:0];
    pick.slot  = slot[FreqW-1:0];
    pick.count = count[FreqW-1:0];
    return pick;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_pick_t want;
    if (!rst_ni) begin
      start_khz = StartReset;
      end_khz   = EndReset;
      bw_khz    = BwReset;
      name_hash = HashSeed;
      pending_picks_q.delete();
      waiting = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BAND_START: start_khz = cfg_wdata_i;
          REG_BAND_END:   end_khz   = cfg_wdata_i;
          REG_CHANNEL_BW: bw_khz    = cfg_wdata_i[BwW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_picks_q.size() == 0) begin
          report_mismatch($sformatf("result freq %0d slot %0d count %0d with no request pending",
                                    centre_freq_hz_i, slot_index_i, channel_count_i));
        end else begin
          want = pending_picks_q.pop_front();
          if (centre_freq_hz_i !== want.freq || slot_index_i !== want.slot ||
              channel_count_i !== want.count) begin
            report_mismatch($sformatf("freq %0d/%0d slot %0d/%0d count %0d/%0d (got/exp)",
                                      centre_freq_hz_i, want.freq, slot_index_i, want.slot,
                                      channel_count_i, want.count));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        name_hash = (name_hash << 5) + name_hash + 32'(name_byte_i);
        if (last_byte_i) begin
          pending_picks_q.push_back(pick_slot(name_hash));
          name_hash = HashSeed;
        end
      end
      waiting = pending_picks_q.size();
    end
  end

endmodule

/* sim/hashed_channel_slot_frequency_top_test.sv */
module hashed_channel_slot_frequency_top_test;
  import hcsf_pkg::*;

  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 80;
  localparam int PhaseItems   = 115;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_BAND_START;
  logic [FreqW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         name_byte = 8'd0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [HzW-1:0]     centre_freq_hz;
  logic [FreqW-1:0]   slot_index;
  logic [FreqW-1:0]   channel_count;
  int                 fail_count;
  int                 picks_pending;
  int                 cycles = 0;
  bit                 calm = 1'b0;
  bit                 sender_gaps = 1'b1;

  hashed_channel_slot_frequency_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .name_byte_i      (name_byte),
    .last_byte_i      (last_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .centre_freq_hz_o (centre_freq_hz),
    .slot_index_o     (slot_index),
    .channel_count_o  (channel_count)
  );

  slot_freq_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .name_byte_i      (name_byte),
    .last_byte_i      (last_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .centre_freq_hz_i (centre_freq_hz),
    .slot_index_i     (slot_index),
    .channel_count_i  (channel_count),
    .fail_count_o     (fail_count),
    .pending_o        (picks_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side back-pressure: short stall bursts and longer free stretches
  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(1, 8);
        end else if ($urandom_range(0, 29) == 0) begin
          free_left = $urandom_range(20, 200);
        end
      end
    end
  end

  task automatic send_name_byte(input logic [7:0] b, input logic last);
    if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    name_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (picks_pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_band_setting(input logic [FreqW-1:0] start_khz,
                                    input logic [FreqW-1:0] end_khz,
                                    input logic [BwW-1:0] bw_khz);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_BAND_START;
    cfg_wdata <= start_khz;
    @(negedge clk);
    cfg_idx   <= REG_BAND_END;
    cfg_wdata <= end_khz;
    @(negedge clk);
    cfg_idx   <= REG_CHANNEL_BW;
    cfg_wdata <= FreqW'(bw_khz);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [FreqW-1:0] start_khz;
    logic [FreqW-1:0] end_khz;
    logic [BwW-1:0]   bw_khz;
    int               end_odds;
    bit               last;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset band: one-byte and longer names, extreme bytes, a wrapping hash
    send_name_byte(8'h00, 1'b1);
    send_name_byte(8'hff, 1'b1);
    send_name_byte(8'h61, 1'b0);
    send_name_byte(8'h62, 1'b1);
    repeat (7) send_name_byte(8'hff, 1'b0);
    send_name_byte(8'hff, 1'b1);
    send_name_byte(8'h80, 1'b0);
    send_name_byte(8'h01, 1'b0);
    send_name_byte(8'h7f, 1'b1);
    drain_results();

    for (int phase = 0; phase < 16; phase++) begin
      case (phase)
        0: begin start_khz = 22'd0;       end_khz = 22'd4194303; bw_khz = 12'd1;    end
        1: begin start_khz = 22'd4194303; end_khz = 22'd4194303; bw_khz = 12'd4095; end
        2: begin start_khz = 22'd1000000; end_khz = 22'd5000;    bw_khz = 12'd100;  end
        3: begin start_khz = 22'd900000;  end_khz = 22'd900100;  bw_khz = 12'd250;  end
        4: begin start_khz = 22'd902000;  end_khz = 22'd928000;  bw_khz = 12'd0;    end
        5: begin start_khz = 22'd0;       end_khz = 22'd4194303; bw_khz = 12'd4095; end
        6: begin start_khz = 22'd4194302; end_khz = 22'd4194303; bw_khz = 12'd1;    end
        7: begin start_khz = StartReset;  end_khz = EndReset;    bw_khz = BwReset;  end
        default: begin
          start_khz = FreqW'($urandom_range(0, 4194303));
          if ($urandom_range(0, 3) == 0) begin
            end_khz = FreqW'($urandom_range(0, 4194303));
          end else begin
            end_khz = FreqW'($urandom_range(int'(start_khz), 4194303));
          end
          if ($urandom_range(0, 2) == 0) begin
            bw_khz = BwW'($urandom_range(1, 16));
          end else begin
            bw_khz = BwW'($urandom_range(1, 4095));
          end
        end
      endcase
      write_band_setting(start_khz, end_khz, bw_khz);
      calm        = (phase == 15);
      sender_gaps = ($urandom_range(0, 3) != 0);
      end_odds    = $urandom_range(1, 8);
      for (int i = 0; i < PhaseItems; i++) begin
        last = ($urandom_range(0, end_odds) == 0) || (phase == 15 && i == PhaseItems - 1);
        send_name_byte(8'($urandom_range(0, 255)), last);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/hcsf_pkg.sv
hw/rtl/hcsf_ctrl.sv
hw/rtl/hcsf_dp.sv
hw/rtl/hashed_channel_slot_frequency_top.sv
sim/slot_freq_checker.sv
sim/hashed_channel_slot_frequency_top_test.sv
